// File: rtl/core/two_tier_sample_decimator_macros.svh
// ----------------------------------------------------------------------------
// Two-tier sample decimator: assertion macros
// Clocked concurrent checks sampled on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TWO_TIER_SAMPLE_DECIMATOR_MACROS_SVH
`define TWO_TIER_SAMPLE_DECIMATOR_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define TTSD_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define TTSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ttsd_pkg.sv
// ----------------------------------------------------------------------------
// ttsd_pkg
// Item types, lane layout and rounding helper of the two-tier sample decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package ttsd_pkg;

  localparam int NREAD       = 6;
  localparam int SUM_W       = 20;
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_W     = 25;
  localparam int HALF_W      = 4;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam int LANE_AMB_TEMP  = 0;
  localparam int LANE_AMB_HUMID = 1;
  localparam int LANE_CH_TEMP   = 2;
  localparam int LANE_CH_HUMID  = 3;
  localparam int LANE_LAMP_TEMP = 4;
  localparam int LANE_PAN_TEMP  = 5;

  localparam logic TIER_FIRST  = 1'b0;
  localparam logic TIER_SECOND = 1'b1;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef sum_t [NREAD-1:0]        lanes_t;
  typedef logic [RECIP_W-1:0]      recip_t;
  typedef logic [HALF_W-1:0]       half_t;

  typedef struct packed {
    logic        [31:0] stamp;
    logic signed [15:0] ambient_temp;
    logic        [13:0] ambient_humid;
    logic signed [15:0] chamber_temp;
    logic        [13:0] chamber_humid;
    logic signed [15:0] lamp_temp;
    logic signed [15:0] panel_temp;
    logic               lamp_on;
  } sample_t;

  typedef struct packed {
    logic               tier;
    logic               last;
    logic        [31:0] out_stamp;
    logic signed [15:0] mean_ambient_temp;
    logic        [13:0] mean_ambient_humid;
    logic signed [15:0] mean_chamber_temp;
    logic        [13:0] mean_chamber_humid;
    logic signed [15:0] mean_lamp_temp;
    logic signed [15:0] mean_panel_temp;
    logic               lamp_majority;
  } result_t;

  // Widen each reading to a sum lane: temperatures sign-extend, humidity zero-extends.
  function automatic lanes_t sample_lanes(sample_t s);
    lanes_t l;
    l[LANE_AMB_TEMP]  = SUM_W'(s.ambient_temp);
    l[LANE_AMB_HUMID] = SUM_W'(s.ambient_humid);
    l[LANE_CH_TEMP]   = SUM_W'(s.chamber_temp);
    l[LANE_CH_HUMID]  = SUM_W'(s.chamber_humid);
    l[LANE_LAMP_TEMP] = SUM_W'(s.lamp_temp);
    l[LANE_PAN_TEMP]  = SUM_W'(s.panel_temp);
    return l;
  endfunction

  // Mean rounded half away from zero: (|sum| + n/2) * ceil(2^25/n) >> 25, sign restored.
  // Exact since |sum| + n/2 < 2^20 and the reciprocal error is below 16.
  function automatic sum_t round_mean(sum_t sum, recip_t recip, half_t half);
    logic              neg;
    logic [SUM_W-1:0]  mag;
    logic [SUM_W-1:0]  num;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  quo;
    neg  = sum[SUM_W-1];
    mag  = neg ? SUM_W'(-sum) : SUM_W'(sum);
    num  = mag + SUM_W'(half);
    prod = PROD_W'(num) * PROD_W'(recip);
    quo  = prod[PROD_W-1:RECIP_SHIFT];
    return neg ? sum_t'(-quo) : sum_t'(quo);
  endfunction

  function automatic result_t make_result(logic tier, logic last, logic [31:0] stamp,
                                          lanes_t m, logic maj);
    result_t r;
    r.tier               = tier;
    r.last               = last;
    r.out_stamp          = stamp;
    r.mean_ambient_temp  = m[LANE_AMB_TEMP][15:0];
    r.mean_ambient_humid = m[LANE_AMB_HUMID][13:0];
    r.mean_chamber_temp  = m[LANE_CH_TEMP][15:0];
    r.mean_chamber_humid = m[LANE_CH_HUMID][13:0];
    r.mean_lamp_temp     = m[LANE_LAMP_TEMP][15:0];
    r.mean_panel_temp    = m[LANE_PAN_TEMP][15:0];
    r.lamp_majority      = maj;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ttsd_stream_if.sv
// ----------------------------------------------------------------------------
// ttsd_stream_if
// Valid/ready channel carrying one item of type payload_t per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttsd_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: rtl/core/two_tier_sample_decimator.sv
// ----------------------------------------------------------------------------
// two_tier_sample_decimator
// Sensor records are folded into windows of FIRST_WINDOW records; each full
// window yields a tier-one mean record, and those are folded into windows of
// SECOND_WINDOW records that yield tier-two mean records.
//
// sample_i is a valid/ready sink of sensor records; result_o is a valid/ready
// source of consolidated records. A record that arrives on a full tier-one
// window yields one result (tier 0), or two results (tier 0, then tier 1)
// when the tier-two window is full too; last marks the final one.
// An accepted item is held in an input register; when it advances, the
// accumulate and rounded-mean logic writes its results into a four-entry
// result queue, which offers them on result_o in order.
// One item is taken per cycle while the queue has room for two results;
// the queue drains one result per cycle while result_o.ready is high, so a
// stalled receiver backs up into the input register and then drops sample_i.ready.
// Reset clears both windows, the input register's valid flag and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_tier_sample_decimator_macros.svh"

module two_tier_sample_decimator #(
  parameter int FIRST_WINDOW  = 6,
  parameter int SECOND_WINDOW = 10
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  ttsd_stream_if.sink         sample_i,
  ttsd_stream_if.source       result_o
);

  localparam int Fill1W = $clog2(FIRST_WINDOW + 1);
  localparam int Fill2W = $clog2(SECOND_WINDOW + 1);

  localparam ttsd_pkg::recip_t Recip1 = ttsd_pkg::RECIP_W'(
    ((64'd1 << ttsd_pkg::RECIP_SHIFT) + FIRST_WINDOW - 1) / FIRST_WINDOW);
  localparam ttsd_pkg::recip_t Recip2 = ttsd_pkg::RECIP_W'(
    ((64'd1 << ttsd_pkg::RECIP_SHIFT) + SECOND_WINDOW - 1) / SECOND_WINDOW);
  localparam ttsd_pkg::half_t Half1 = ttsd_pkg::HALF_W'(FIRST_WINDOW / 2);
  localparam ttsd_pkg::half_t Half2 = ttsd_pkg::HALF_W'(SECOND_WINDOW / 2);

  // Input register
  logic              pipe_valid_q;
  ttsd_pkg::sample_t pipe_q;
  logic              advance;

  // Window state
  ttsd_pkg::lanes_t  sum1_q, sum1_d, sum2_q, sum2_d;
  logic [31:0]       stamp1_q, stamp1_d, stamp2_q, stamp2_d;
  logic [Fill1W-1:0] ones1_q, ones1_d, fill1_q, fill1_d;
  logic [Fill2W-1:0] ones2_q, ones2_d, fill2_q, fill2_d;

  // Result queue
  ttsd_pkg::result_t              queue_q [ttsd_pkg::QDEPTH];
  logic [ttsd_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [ttsd_pkg::QCNT_W-1:0]    cnt_q;
  logic [1:0]                     n_push;
  logic                           pop;

  ttsd_pkg::lanes_t  in_lanes, mean1, mean2;
  ttsd_pkg::result_t res_a, res_b;
  logic              full1, full2, maj1, maj2;

  assign advance        = pipe_valid_q && (cnt_q <= ttsd_pkg::QCNT_W'(ttsd_pkg::QDEPTH - 2));
  assign sample_i.ready = !pipe_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
    end else if (sample_i.valid && sample_i.ready) begin
      pipe_valid_q <= 1'b1;
    end else if (advance) begin
      pipe_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      pipe_q <= sample_i.payload;
    end
  end

  assign full1    = (fill1_q == Fill1W'(FIRST_WINDOW));
  assign full2    = (fill2_q == Fill2W'(SECOND_WINDOW));
  assign maj1     = (ones1_q >= Fill1W'(FIRST_WINDOW / 2));
  assign maj2     = (ones2_q >= Fill2W'(SECOND_WINDOW / 2));
  assign in_lanes = ttsd_pkg::sample_lanes(pipe_q);

  always_comb begin
    for (int i = 0; i < ttsd_pkg::NREAD; i++) begin
      mean1[i] = ttsd_pkg::round_mean(sum1_q[i], Recip1, Half1);
      mean2[i] = ttsd_pkg::round_mean(sum2_q[i], Recip2, Half2);
    end
  end

  assign res_a = ttsd_pkg::make_result(ttsd_pkg::TIER_FIRST, !full2, stamp1_q, mean1, maj1);
  assign res_b = ttsd_pkg::make_result(ttsd_pkg::TIER_SECOND, 1'b1, stamp2_q, mean2, maj2);

  always_comb begin
    sum1_d   = sum1_q;
    stamp1_d = stamp1_q;
    ones1_d  = ones1_q;
    fill1_d  = fill1_q;
    sum2_d   = sum2_q;
    stamp2_d = stamp2_q;
    ones2_d  = ones2_q;
    fill2_d  = fill2_q;
    n_push   = 2'd0;
    if (advance) begin
      if (full1) begin
        n_push = full2 ? 2'd2 : 2'd1;
        // Restart tier one with the new record
        sum1_d   = in_lanes;
        stamp1_d = pipe_q.stamp;
        ones1_d  = Fill1W'(pipe_q.lamp_on);
        fill1_d  = Fill1W'(1);
        // Fold the tier-one record into tier two
        if (full2) begin
          sum2_d   = mean1;
          stamp2_d = stamp1_q;
          ones2_d  = Fill2W'(maj1);
          fill2_d  = Fill2W'(1);
        end else begin
          for (int i = 0; i < ttsd_pkg::NREAD; i++) begin
            sum2_d[i] = sum2_q[i] + mean1[i];
          end
          if (fill2_q == '0) begin
            stamp2_d = stamp1_q;
          end
          ones2_d = ones2_q + Fill2W'(maj1);
          fill2_d = fill2_q + Fill2W'(1);
        end
      end else begin
        for (int i = 0; i < ttsd_pkg::NREAD; i++) begin
          sum1_d[i] = sum1_q[i] + in_lanes[i];
        end
        if (fill1_q == '0) begin
          stamp1_d = pipe_q.stamp;
        end
        ones1_d = ones1_q + Fill1W'(pipe_q.lamp_on);
        fill1_d = fill1_q + Fill1W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum1_q   <= '0;
      stamp1_q <= '0;
      ones1_q  <= '0;
      fill1_q  <= '0;
      sum2_q   <= '0;
      stamp2_q <= '0;
      ones2_q  <= '0;
      fill2_q  <= '0;
    end else begin
      sum1_q   <= sum1_d;
      stamp1_q <= stamp1_d;
      ones1_q  <= ones1_d;
      fill1_q  <= fill1_d;
      sum2_q   <= sum2_d;
      stamp2_q <= stamp2_d;
      ones2_q  <= ones2_d;
      fill2_q  <= fill2_d;
    end
  end

  assign pop              = result_o.valid && result_o.ready;
  assign result_o.valid   = (cnt_q != '0);
  assign result_o.payload = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= res_a;
    end
    if (n_push == 2'd2) begin
      queue_q[wr_ptr_q + ttsd_pkg::QPTR_W'(1)] <= res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ttsd_pkg::QPTR_W'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + ttsd_pkg::QPTR_W'(1);
      end
      cnt_q <= cnt_q + ttsd_pkg::QCNT_W'(n_push) - ttsd_pkg::QCNT_W'(pop);
    end
  end

  `TTSD_ASSERT_ALWAYS(a_queue_bound, cnt_q <= ttsd_pkg::QCNT_W'(ttsd_pkg::QDEPTH), "result queue overflow")
  `TTSD_ASSERT_ALWAYS(a_fill_bound, (fill1_q <= Fill1W'(FIRST_WINDOW)) && (fill2_q <= Fill2W'(SECOND_WINDOW)), "window fill beyond size")
  `TTSD_ASSERT_IMP(a_tier2_last, result_o.valid && result_o.payload.tier, result_o.payload.last, "tier-two result without last")
  `TTSD_ASSERT_NEXT(a_restart, advance && full1, fill1_q == Fill1W'(1), "tier-one window did not restart")

endmodule

`default_nettype wire
